// ----- rtl/core/matrix4_inverse_cofactor_defines.svh -----
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX4_INVERSE_COFACTOR_DEFINES_SVH
`define MATRIX4_INVERSE_COFACTOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mtxinv_pkg.sv -----
// Package with shared constants, state codes and index helpers for the matrix inverse.
`timescale 1ns / 1ps
`default_nettype none

package mtxinv_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam logic [62:0] EPS_RESET = 63'd4295;
    localparam logic [3:0]  LAST_ELEM = 4'd15;

    typedef enum logic [8:0] {
        ST_LOAD  = 9'b000000001,
        ST_COF   = 9'b000000010,
        ST_DET   = 9'b000000100,
        ST_ROUND = 9'b000001000,
        ST_CLASS = 9'b000010000,
        ST_PREP  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_SAT   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // Index idx of the three rows (or columns) that remain once excl is struck out.
    function automatic logic [1:0] skip_index(input logic [1:0] excl, input logic [1:0] idx);
        return (idx >= excl) ? idx + 2'd1 : idx;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mtxinv_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module mtxinv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/core/matrix4_inverse_cofactor.sv -----
// 4x4 fixed-point matrix inverse by cofactor expansion on one shared multiplier.
// Sequence: after the sixteenth element request the cofactors are computed, then the
//   determinant, which is rounded and classified; then each inverse element is divided out
//   (one divider bit per cycle), or set directly when the matrix is singular.
// Throughput: one element request per cycle while loading; no input is taken while computing.
// Reset (rst_n, asynchronous, active low) empties the load counter and restores epsilon.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_inverse_cofactor
    import mtxinv_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // Configuration: singular_epsilon register.
    input  wire logic        cfg_we,
    input  wire logic [62:0] cfg_wdata,
    // Element requests. s_tdata: element_value.
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
    // Inverse requests. m_tdata: inverse_value, out_row, out_col, determinant.
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [((DATA_WIDTH+68+7)/8)*8-1:0]          m_tdata,
    // m_tuser: singular.
    output logic [0:0]                                  m_tuser,
    output logic                                        m_tlast
);

    `include "matrix4_inverse_cofactor_defines.svh"

    localparam int DW     = DATA_WIDTH;
    localparam int PW     = 2 * DW + 2;            // product and 2x2 minor
    localparam int CW     = 3 * DW + 3;            // exact cofactor
    localparam int BW     = 4 * DW;                // operand split into four chunks
    localparam int AW     = 4 * DW + 8;            // accumulator, holds the determinant
    localparam int QW     = DW + 1;
    localparam int QN     = QW + 1;                // quotient bits, top one flags overflow
    localparam int VW     = AW + QW + 2 * FRAC_BITS + 4;
    localparam int CNT_W  = $clog2(QN + 1);
    localparam int OUT_TW = ((DW + 68 + 7) / 8) * 8;
    localparam int RSH    = 4 * FRAC_BITS - 32;
    localparam logic signed [AW-1:0] RBIAS =
        AW'(RSH > 0) << ((RSH > 0) ? RSH - 1 : 0);
    localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE_VAL =
        (FRAC_BITS >= DW - 1) ? MAX_VAL : (DW'(1) << FRAC_BITS);

    // Control registers.
    state_t             state_reg, state_next;
    logic [3:0]         load_cnt_reg, load_cnt_next;
    logic [3:0]         k_reg, k_next;          // cofactor index, later output index
    logic [1:0]         t_reg, t_next;          // expansion term, or determinant column
    logic [2:0]         op_reg, op_next;        // micro-operation within a term
    logic [1:0]         ph_reg, ph_next;        // address, multiply, accumulate
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [62:0]        eps_reg;

    // Datapath registers.
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [PW-1:0] minor_reg, minor_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [CW-1:0] cof_mem [16];
    logic                 cof_we;
    logic [63:0]          detq_reg, detq_next;
    logic                 det_zero_reg, det_zero_next;
    logic [AW-1:0]        dabs_reg, dabs_next;
    logic                 sing_reg, sing_next;
    logic [VW-1:0]        rem_reg, rem_next;
    logic [VW-1:0]        dsh_reg, dsh_next;
    logic [QN-1:0]        q_reg, q_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        inv_reg, inv_next;

    // Element store.
    logic          s_acc;
    logic [3:0]    raddr_a, raddr_b;
    logic [DW-1:0] rdata_a, rdata_b;

    assign s_acc = s_tvalid && s_tready;

    mtxinv_ram #(
        .WIDTH (DW),
        .DEPTH (16)
    ) u_matrix_store (
        .clk     (clk),
        .we      (s_acc),
        .waddr   (load_cnt_reg),
        .wdata   (s_tdata[DW-1:0]),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // Row and column selection for the 3x3 submatrix of cofactor k, expanded along its
    // first row: term t multiplies a[0][t] by the minor of columns p and q.
    logic [1:0] r_idx, c_idx, p_idx, q_idx;
    logic [1:0] rs0, rs1, rs2, csm, csp, csq;

    always_comb
    begin
        r_idx = k_reg[3:2];
        c_idx = k_reg[1:0];
        p_idx = (t_reg == 2'd0) ? 2'd1 : 2'd0;
        q_idx = (t_reg == 2'd2) ? 2'd1 : 2'd2;
        rs0   = skip_index(r_idx, 2'd0);
        rs1   = skip_index(r_idx, 2'd1);
        rs2   = skip_index(r_idx, 2'd2);
        csm   = skip_index(c_idx, t_reg);
        csp   = skip_index(c_idx, p_idx);
        csq   = skip_index(c_idx, q_idx);
    end

    always_comb
    begin
        raddr_a = {rs0, csm};
        raddr_b = {rs2, csq};
        if (state_reg == ST_DET)
        begin
            raddr_a = {2'd0, t_reg};
        end
        else if (op_reg == 3'd0)
        begin
            raddr_a = {rs1, csp};
            raddr_b = {rs2, csq};
        end
        else if (op_reg == 3'd1)
        begin
            raddr_a = {rs1, csq};
            raddr_b = {rs2, csp};
        end
    end

    // Second operand: a stored element, or one chunk of the minor or of a cofactor.
    // Lower chunks are unsigned, the top chunk carries the sign.
    logic [3:0]           cof_idx;
    logic signed [CW-1:0] cof_rd;
    logic [BW-1:0]        chunk_src;
    logic [1:0]           chunk_sel;
    logic                 chunk_top;
    logic [DW-1:0]        chunk_raw;
    logic signed [DW:0]   mult_a, mult_b;
    logic signed [PW-1:0] mult_res;

    assign cof_idx = (state_reg == ST_DET) ? {2'd0, t_reg} : {k_reg[1:0], k_reg[3:2]};
    assign cof_rd  = cof_mem[cof_idx];

    always_comb
    begin
        if (state_reg == ST_DET)
        begin
            chunk_src = {{(BW-CW){cof_rd[CW-1]}}, cof_rd};
            chunk_sel = op_reg[1:0];
            chunk_top = (op_reg[1:0] == 2'd3);
        end
        else
        begin
            chunk_src = {{(BW-PW){minor_reg[PW-1]}}, minor_reg};
            chunk_sel = 2'(op_reg - 3'd2);
            chunk_top = (op_reg == 3'd4);
        end
        case (chunk_sel)
            2'd0:    chunk_raw = chunk_src[DW-1:0];
            2'd1:    chunk_raw = chunk_src[2*DW-1:DW];
            2'd2:    chunk_raw = chunk_src[3*DW-1:2*DW];
            default: chunk_raw = chunk_src[4*DW-1:3*DW];
        endcase
        mult_a = {rdata_a[DW-1], rdata_a};
        if ((state_reg == ST_COF) && (op_reg < 3'd2))
        begin
            mult_b = {rdata_b[DW-1], rdata_b};
        end
        else
        begin
            mult_b = {chunk_top & chunk_raw[DW-1], chunk_raw};
        end
        mult_res = mult_a * mult_b;
    end

    // Accumulation of a product placed at its chunk position.
    logic [AW-1:0]        prod_ext, prod_shift;
    logic                 acc_sub;
    logic signed [AW-1:0] acc_sum;

    always_comb
    begin
        prod_ext = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
        case (chunk_sel)
            2'd0:    prod_shift = prod_ext;
            2'd1:    prod_shift = prod_ext << DW;
            2'd2:    prod_shift = prod_ext << (2 * DW);
            default: prod_shift = prod_ext << (3 * DW);
        endcase
        // The middle term is subtracted; an odd cofactor position flips every sign.
        acc_sub = (state_reg == ST_COF) && ((t_reg == 2'd1) ^ (r_idx[0] ^ c_idx[0]));
        acc_sum = acc_sub ? acc_reg - $signed(prod_shift) : acc_reg + $signed(prod_shift);
    end

    // Rounding of the determinant to Q32.32 and saturation to 64 bits.
    logic signed [AW-1:0] rnd_sum, rnd_shr;
    logic                 rnd_fits;
    logic [63:0]          det_mag;
    logic [CW-1:0]        z_abs;
    logic [QN-1:0]        q_neg;
    logic                 div_ge;
    logic [1:0]           out_i, out_j;

    always_comb
    begin
        rnd_sum  = acc_reg + RBIAS;
        rnd_shr  = rnd_sum >>> RSH;
        rnd_fits = (&rnd_shr[AW-1:63]) || !(|rnd_shr[AW-1:63]);
        det_mag  = detq_reg[63] ? (~detq_reg + 64'd1) : detq_reg;
        z_abs    = cof_rd[CW-1] ? CW'(-cof_rd) : CW'(cof_rd);
        q_neg    = ~q_reg + QN'(1);
        div_ge   = rem_reg >= dsh_reg;
        out_i    = k_reg[3:2];
        out_j    = k_reg[1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        op_next       = op_reg;
        ph_next       = ph_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        minor_next    = minor_reg;
        acc_next      = acc_reg;
        cof_we        = 1'b0;
        detq_next     = detq_reg;
        det_zero_next = det_zero_reg;
        dabs_next     = dabs_reg;
        sing_next     = sing_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        neg_next      = neg_reg;
        inv_next      = inv_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    if (load_cnt_reg == LAST_ELEM)
                    begin
                        load_cnt_next = 4'd0;
                        state_next    = ST_COF;
                        acc_next      = '0;
                        k_next        = 4'd0;
                        t_next        = 2'd0;
                        op_next       = 3'd0;
                        ph_next       = 2'd0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 4'd1;
                    end
                end
            end

            ST_COF, ST_DET:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        prod_next = mult_res;
                        ph_next   = 2'd2;
                    end
                    2'd2:
                    begin
                        ph_next = 2'd0;
                        if (state_reg == ST_DET)
                        begin
                            acc_next = acc_sum;
                            op_next  = op_reg + 3'd1;
                            if (op_reg == 3'd3)
                            begin
                                op_next = 3'd0;
                                t_next  = t_reg + 2'd1;
                                if (t_reg == 2'd3)
                                begin
                                    state_next = ST_ROUND;
                                end
                            end
                        end
                        else if (op_reg == 3'd0)
                        begin
                            minor_next = prod_reg;
                            op_next    = 3'd1;
                        end
                        else if (op_reg == 3'd1)
                        begin
                            minor_next = minor_reg - prod_reg;
                            op_next    = 3'd2;
                        end
                        else
                        begin
                            acc_next = acc_sum;
                            op_next  = op_reg + 3'd1;
                            if (op_reg == 3'd4)
                            begin
                                op_next = 3'd0;
                                t_next  = t_reg + 2'd1;
                                if (t_reg == 2'd2)
                                begin
                                    // Third term done: the cofactor is complete.
                                    t_next   = 2'd0;
                                    cof_we   = 1'b1;
                                    acc_next = '0;
                                    k_next   = k_reg + 4'd1;
                                    if (k_reg == LAST_ELEM)
                                    begin
                                        state_next = ST_DET;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        ph_next = 2'd0;
                    end
                endcase
            end

            ST_ROUND:
            begin
                det_zero_next = (acc_reg == '0);
                if (rnd_fits)
                begin
                    detq_next = rnd_shr[63:0];
                end
                else
                begin
                    detq_next = rnd_shr[AW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end
                state_next = ST_CLASS;
            end

            ST_CLASS:
            begin
                sing_next  = (det_mag <= {1'b0, eps_reg}) || det_zero_reg;
                dabs_next  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
                k_next     = 4'd0;
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                if (sing_reg)
                begin
                    if (out_i != out_j)
                    begin
                        inv_next = '0;
                    end
                    else
                    begin
                        inv_next = (out_i == 2'd3) ? ONE_VAL : MAX_VAL;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    // Rounded quotient: (2|z| 2^(2F) + |d|) / (2|d|).
                    rem_next   = (VW'(z_abs) << (2 * FRAC_BITS + 1)) + VW'(dabs_reg);
                    dsh_next   = VW'(dabs_reg) << (QW + 1);
                    q_next     = '0;
                    cnt_next   = CNT_W'(QN);
                    neg_next   = cof_rd[CW-1] ^ acc_reg[AW-1];
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[QN-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_SAT;
                end
            end

            ST_SAT:
            begin
                if (neg_reg)
                begin
                    inv_next = (q_reg > QN'(MAX_VAL) + QN'(1)) ? MIN_VAL : q_neg[DW-1:0];
                end
                else
                begin
                    inv_next = (q_reg > QN'(MAX_VAL)) ? MAX_VAL : q_reg[DW-1:0];
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (m_tready)
                begin
                    k_next = k_reg + 4'd1;
                    if (k_reg == LAST_ELEM)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= 4'd0;
            k_reg        <= 4'd0;
            t_reg        <= 2'd0;
            op_reg       <= 3'd0;
            ph_reg       <= 2'd0;
            cnt_reg      <= '0;
            eps_reg      <= EPS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            t_reg        <= t_next;
            op_reg       <= op_next;
            ph_reg       <= ph_next;
            cnt_reg      <= cnt_next;
            if (cfg_we)
            begin
                eps_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        minor_reg    <= minor_next;
        acc_reg      <= acc_next;
        detq_reg     <= detq_next;
        det_zero_reg <= det_zero_next;
        dabs_reg     <= dabs_next;
        sing_reg     <= sing_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        inv_reg      <= inv_next;
        if (cof_we)
        begin
            cof_mem[k_reg] <= acc_sum[CW-1:0];
        end
    end

    // The result register is shown in its own state; the input side waits meanwhile.
    assign s_tready   = (state_reg == ST_LOAD);
    assign m_tvalid   = (state_reg == ST_OUT);
    assign m_tdata    = OUT_TW'({detq_reg, out_j, out_i, inv_reg});
    assign m_tuser[0] = sing_reg;
    assign m_tlast    = (k_reg == LAST_ELEM);

    `MI_ASSERT_IMP(a_one_side_open, m_tvalid, !s_tready, "input taken while a result waits")
    `MI_ASSERT_IMP(a_last_position, m_tvalid && m_tlast, m_tdata[DW+3:DW] == 4'hF,
        "last result not at row 3 column 3")
    `MI_ASSERT_IMP(a_fallback_offdiag,
        m_tvalid && m_tuser[0] && (m_tdata[DW+1:DW] != m_tdata[DW+3:DW+2]),
        m_tdata[DW-1:0] == '0, "fallback matrix has a nonzero off-diagonal entry")
    `MI_ASSERT_NXT(a_reload_after_last, m_tvalid && m_tready && m_tlast, s_tready,
        "block did not return to loading after the last result")

endmodule

`default_nettype wire
